// ===== rtl/kscd_pkg.sv =====
// Package for the keyboard scancode decoder: modifier and result types,
// action codes and the plain/shifted character tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kscd_pkg;

    localparam int ScanWidth   = 8;
    localparam int ActionWidth = 3;
    localparam int CharWidth   = 7;
    localparam int ScreenWidth = 2;

    localparam logic [ActionWidth-1:0] ACT_NONE   = 3'd0;
    localparam logic [ActionWidth-1:0] ACT_CHAR   = 3'd1;
    localparam logic [ActionWidth-1:0] ACT_CLEAR  = 3'd2;
    localparam logic [ActionWidth-1:0] ACT_HALT   = 3'd3;
    localparam logic [ActionWidth-1:0] ACT_SCREEN = 3'd4;

    // Release codes (bit 7 set)
    localparam logic [ScanWidth-1:0] REL_LSHIFT = 8'hAA;
    localparam logic [ScanWidth-1:0] REL_RSHIFT = 8'hB6;
    localparam logic [ScanWidth-1:0] REL_CTRL   = 8'h9D;
    localparam logic [ScanWidth-1:0] REL_ALT    = 8'hB8;

    // Make codes
    localparam logic [CharWidth-1:0] KEY_LSHIFT = 7'd42;
    localparam logic [CharWidth-1:0] KEY_RSHIFT = 7'd54;
    localparam logic [CharWidth-1:0] KEY_CTRL   = 7'd29;
    localparam logic [CharWidth-1:0] KEY_ALT    = 7'd56;
    localparam logic [CharWidth-1:0] KEY_CAPS   = 7'd58;
    localparam logic [CharWidth-1:0] KEY_L      = 7'd38;
    localparam logic [CharWidth-1:0] KEY_C      = 7'd46;
    localparam logic [CharWidth-1:0] KEY_F1     = 7'd59;
    localparam logic [CharWidth-1:0] KEY_F3     = 7'd61;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } t_mods;

    typedef struct packed {
        logic [ActionWidth-1:0] action;
        logic [CharWidth-1:0]   character;
        logic [ScreenWidth-1:0] screen_index;
    } t_result;

    // US layout, unshifted; zero means no character
    function automatic logic [CharWidth-1:0] plain_char(input logic [CharWidth-1:0] c);
        logic [CharWidth-1:0] v;
        case (c)
            7'd1:  v = 7'h1B;  7'd2:  v = 7'h31;  7'd3:  v = 7'h32;  7'd4:  v = 7'h33;
            7'd5:  v = 7'h34;  7'd6:  v = 7'h35;  7'd7:  v = 7'h36;  7'd8:  v = 7'h37;
            7'd9:  v = 7'h38;  7'd10: v = 7'h39;  7'd11: v = 7'h30;  7'd12: v = 7'h2D;
            7'd13: v = 7'h3D;  7'd14: v = 7'h08;  7'd15: v = 7'h09;  7'd16: v = 7'h71;
            7'd17: v = 7'h77;  7'd18: v = 7'h65;  7'd19: v = 7'h72;  7'd20: v = 7'h74;
            7'd21: v = 7'h79;  7'd22: v = 7'h75;  7'd23: v = 7'h69;  7'd24: v = 7'h6F;
            7'd25: v = 7'h70;  7'd26: v = 7'h5B;  7'd27: v = 7'h5D;  7'd28: v = 7'h0A;
            7'd30: v = 7'h61;  7'd31: v = 7'h73;  7'd32: v = 7'h64;  7'd33: v = 7'h66;
            7'd34: v = 7'h67;  7'd35: v = 7'h68;  7'd36: v = 7'h6A;  7'd37: v = 7'h6B;
            7'd38: v = 7'h6C;  7'd39: v = 7'h3B;  7'd40: v = 7'h27;  7'd41: v = 7'h60;
            7'd43: v = 7'h5C;  7'd44: v = 7'h7A;  7'd45: v = 7'h78;  7'd46: v = 7'h63;
            7'd47: v = 7'h76;  7'd48: v = 7'h62;  7'd49: v = 7'h6E;  7'd50: v = 7'h6D;
            7'd51: v = 7'h2C;  7'd52: v = 7'h2E;  7'd53: v = 7'h2F;  7'd55: v = 7'h2A;
            7'd57: v = 7'h20;  7'd74: v = 7'h2D;  7'd78: v = 7'h2B;
            default: v = 7'h00;
        endcase
        return v;
    endfunction

    // US layout, shifted
    function automatic logic [CharWidth-1:0] upper_char(input logic [CharWidth-1:0] c);
        logic [CharWidth-1:0] v;
        case (c)
            7'd1:  v = 7'h1B;  7'd2:  v = 7'h21;  7'd3:  v = 7'h40;  7'd4:  v = 7'h23;
            7'd5:  v = 7'h24;  7'd6:  v = 7'h25;  7'd7:  v = 7'h5E;  7'd8:  v = 7'h26;
            7'd9:  v = 7'h2A;  7'd10: v = 7'h28;  7'd11: v = 7'h29;  7'd12: v = 7'h5F;
            7'd13: v = 7'h2B;  7'd14: v = 7'h08;  7'd15: v = 7'h09;  7'd16: v = 7'h51;
            7'd17: v = 7'h57;  7'd18: v = 7'h45;  7'd19: v = 7'h52;  7'd20: v = 7'h54;
            7'd21: v = 7'h59;  7'd22: v = 7'h55;  7'd23: v = 7'h49;  7'd24: v = 7'h4F;
            7'd25: v = 7'h50;  7'd26: v = 7'h7B;  7'd27: v = 7'h7D;  7'd28: v = 7'h0A;
            7'd30: v = 7'h41;  7'd31: v = 7'h53;  7'd32: v = 7'h44;  7'd33: v = 7'h46;
            7'd34: v = 7'h47;  7'd35: v = 7'h48;  7'd36: v = 7'h4A;  7'd37: v = 7'h4B;
            7'd38: v = 7'h4C;  7'd39: v = 7'h3A;  7'd40: v = 7'h22;  7'd41: v = 7'h7E;
            7'd43: v = 7'h7C;  7'd44: v = 7'h5A;  7'd45: v = 7'h58;  7'd46: v = 7'h43;
            7'd47: v = 7'h56;  7'd48: v = 7'h42;  7'd49: v = 7'h4E;  7'd50: v = 7'h4D;
            7'd51: v = 7'h3C;  7'd52: v = 7'h3E;  7'd53: v = 7'h3F;  7'd55: v = 7'h2A;
            7'd57: v = 7'h20;  7'd74: v = 7'h2D;  7'd78: v = 7'h2B;
            default: v = 7'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kscd_decode.sv =====
// Combinational decode of one scancode against the current modifier flags.
// Gives the result and the next modifier flags. Depends on kscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kscd_decode (
    input  wire logic [kscd_pkg::ScanWidth-1:0] i_code,
    input  wire kscd_pkg::t_mods                i_mods,
    output kscd_pkg::t_mods                     o_mods,
    output kscd_pkg::t_result                   o_result
);
    import kscd_pkg::*;

    logic [CharWidth-1:0] make;
    logic                 accepted;
    logic                 letter;
    logic                 use_upper;
    logic [CharWidth-1:0] table_val;
    logic [CharWidth-1:0] fkey_off;

    assign make     = i_code[CharWidth-1:0];
    assign fkey_off = make - KEY_F1;

    always_comb begin
        accepted  = (make inside {[7'd2:7'd62], 7'd74, 7'd78});
        letter    = (make inside {[7'd16:7'd25], [7'd30:7'd38], [7'd44:7'd50]});
        use_upper = (i_mods.caps && letter) ||
                    (i_mods.shift && (make inside {[7'd2:7'd53]}));
        table_val = use_upper ? upper_char(make) : plain_char(make);
    end

    always_comb begin
        o_mods   = i_mods;
        o_result = '{action: ACT_NONE, character: '0, screen_index: '0};
        if (i_code[ScanWidth-1]) begin
            if (i_code == REL_LSHIFT || i_code == REL_RSHIFT) begin
                o_mods.shift = 1'b0;
            end else if (i_code == REL_CTRL) begin
                o_mods.ctrl = 1'b0;
            end else if (i_code == REL_ALT) begin
                o_mods.alt = 1'b0;
            end
        end else if (accepted) begin
            if (make == KEY_LSHIFT || make == KEY_RSHIFT) begin
                o_mods.shift = 1'b1;
            end else if (make == KEY_CTRL) begin
                o_mods.ctrl = 1'b1;
            end else if (make == KEY_ALT) begin
                o_mods.alt = 1'b1;
            end else if (make == KEY_CAPS) begin
                o_mods.caps = ~i_mods.caps;
            end else if (i_mods.ctrl && make == KEY_L) begin
                o_result.action = ACT_CLEAR;
            end else if (i_mods.ctrl && make == KEY_C) begin
                o_result.action = ACT_HALT;
            end else if (make >= KEY_F1 && make <= KEY_F3) begin
                if (i_mods.alt) begin
                    o_result.action       = ACT_SCREEN;
                    o_result.screen_index = fkey_off[ScreenWidth-1:0];
                end
            end else if (table_val != '0) begin
                o_result.action    = ACT_CHAR;
                o_result.character = table_val;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keyboard_scancode_decoder_unit.sv =====
// Top level of the set-1 keyboard scancode decoder: input register,
// modifier flags, result register. Depends on kscd_pkg and kscd_decode.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------
// scancode  | i_valid / o_ready    | i_scan_code[7:0]
// result    | o_valid / i_ready    | o_action[2:0], o_character[6:0],
//           |                      | o_screen_index[1:0]
//
// Two register stages: a request is captured in the input register, decoded
// against the modifier flags by combinational logic and written to the result
// register; o_valid rises when it moves there, which waits while a stalled
// result is held. One request per cycle is sustained while i_ready stays high,
// with the flags fed back from their register through the decode logic.
// Every request yields exactly one result (action none for ignored codes).
// Reset (i_rst_n low, synchronous) empties both stages and clears all flags.
// A stall on i_ready holds the result; an empty input stage still takes one more
// request, then o_ready drops until the result drains.

module keyboard_scancode_decoder_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [kscd_pkg::ScanWidth-1:0]  i_scan_code,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [kscd_pkg::ActionWidth-1:0]     o_action,
    output logic [kscd_pkg::CharWidth-1:0]       o_character,
    output logic [kscd_pkg::ScreenWidth-1:0]     o_screen_index
);
    import kscd_pkg::*;

    // input stage
    logic                 r_in_valid;
    logic [ScanWidth-1:0] r_in_code;
    // modifier flags
    t_mods                r_mods;
    t_mods                n_mods;
    // result stage
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic out_free;
    logic advance;

    // result register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    kscd_decode u_decode (
        .i_code   (r_in_code),
        .i_mods   (r_mods),
        .o_mods   (n_mods),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_code <= i_scan_code;
        end
    end

    // flags advance only when a decoded request moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mods <= n_mods;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_out.action;
    assign o_character    = r_out.character;
    assign o_screen_index = r_out.screen_index;

endmodule

`default_nettype wire

// ===== rtl/kscd_checker.sv =====
// Port-level checks for keyboard_scancode_decoder_unit, with the bind that
// attaches them. Depends on kscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kscd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic [kscd_pkg::ActionWidth-1:0] o_action,
    input wire logic [kscd_pkg::CharWidth-1:0]   o_character,
    input wire logic [kscd_pkg::ScreenWidth-1:0] o_screen_index
);
    import kscd_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action) && $stable(o_character))
        else $error("result dropped or changed under stall");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action != ACT_CHAR |-> o_character == '0)
        else $error("character set without character action");

    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_CHAR |-> o_character != '0)
        else $error("character action with empty code");

    a_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_action == ACT_SCREEN && o_screen_index != 2'd3) ||
                    (o_action != ACT_SCREEN && o_screen_index == '0))
        else $error("bad screen index");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind keyboard_scancode_decoder_unit kscd_checker u_kscd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_action       (o_action),
    .o_character    (o_character),
    .o_screen_index (o_screen_index)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for keyboard_scancode_decoder_unit: a directed scancode table,
// then a weighted random stream, each result checked against an in-bench decoder.
// Depends on kscd_pkg (action codes, key codes, result and modifier types).
`timescale 1ns / 1ps

module tb_top;

    import kscd_pkg::*;

    localparam int RandomCodes = 2000;
    // Both sides stop idling for this many codes at the end of the stream
    localparam int QuietCodes  = 300;
    // Sender holds off here until every pending result has drained
    localparam int DrainPoint  = 1000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [ScanWidth-1:0]   i_scan_code = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [ActionWidth-1:0] o_action;
    logic [CharWidth-1:0]   o_character;
    logic [ScreenWidth-1:0] o_screen_index;

    keyboard_scancode_decoder_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_scan_code    (i_scan_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_character    (o_character),
        .o_screen_index (o_screen_index)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // US layout, indexed by make code; zero means no character
    logic [6:0] lower_keys [0:79] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00
    };

    logic [6:0] upper_keys [0:79] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00
    };

    // Modifier flags as the bench believes them to be
    t_mods   held_mods = '0;
    t_result pending_results [$];

    int errors = 0;
    int codes_sent = 0;
    int results_checked = 0;
    int chars_seen = 0;
    int controls_seen = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    // Decode one scancode against held_mods and update the flags
    function automatic t_result decode_key(input logic [7:0] code);
        t_result    r;
        logic [6:0] k;
        logic [6:0] ch;
        bit         letter;
        r = '0;
        k = code[6:0];
        letter = (k >= 7'd16 && k <= 7'd25) || (k >= 7'd30 && k <= 7'd38) ||
                 (k >= 7'd44 && k <= 7'd50);
        if (code[7]) begin
            // only the four modifier releases matter
            if (code == REL_LSHIFT || code == REL_RSHIFT)
                held_mods.shift = 1'b0;
            else if (code == REL_CTRL)
                held_mods.ctrl = 1'b0;
            else if (code == REL_ALT)
                held_mods.alt = 1'b0;
        end else if ((k >= 7'd2 && k <= 7'd62) || k == 7'd74 || k == 7'd78) begin
            if (k == KEY_LSHIFT || k == KEY_RSHIFT) begin
                held_mods.shift = 1'b1;
            end else if (k == KEY_CTRL) begin
                held_mods.ctrl = 1'b1;
            end else if (k == KEY_ALT) begin
                held_mods.alt = 1'b1;
            end else if (k == KEY_CAPS) begin
                held_mods.caps = ~held_mods.caps;
            end else if (held_mods.ctrl && k == KEY_L) begin
                r.action = ACT_CLEAR;
            end else if (held_mods.ctrl && k == KEY_C) begin
                r.action = ACT_HALT;
            end else if (k >= KEY_F1 && k <= KEY_F3) begin
                // function keys only switch screens with alt held
                if (held_mods.alt) begin
                    r.action = ACT_SCREEN;
                    r.screen_index = 2'(k - KEY_F1);
                end
            end else begin
                if (held_mods.caps && letter)
                    ch = upper_keys[k];
                else if (held_mods.shift && k <= 7'd53)
                    ch = upper_keys[k];
                else
                    ch = lower_keys[k];
                if (ch != 7'd0) begin
                    r.action = ACT_CHAR;
                    r.character = ch;
                end
            end
        end
        return r;
    endfunction

    // Directed table: code, whether the expected result is typed in, result
    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        t_result    res;
    } t_key_row;

    localparam int DirectedRows = 25;

    t_key_row key_rows [0:DirectedRows-1] = '{
        {8'd0,   1'b1, ACT_NONE,   7'd0,  2'd0},  // below accepted range
        {8'd255, 1'b1, ACT_NONE,   7'd0,  2'd0},  // stray release, top of range
        {8'd1,   1'b1, ACT_NONE,   7'd0,  2'd0},  // escape is not accepted
        {8'd2,   1'b1, ACT_CHAR,   7'h31, 2'd0},  // plain '1'
        {8'd42,  1'b1, ACT_NONE,   7'd0,  2'd0},  // left shift down
        {8'd2,   1'b0, ACT_NONE,   7'd0,  2'd0},
        {8'd40,  1'b0, ACT_NONE,   7'd0,  2'd0},  // shifted quote
        {8'd43,  1'b0, ACT_NONE,   7'd0,  2'd0},  // shifted backslash
        {8'hAA,  1'b1, ACT_NONE,   7'd0,  2'd0},  // left shift up
        {8'd54,  1'b1, ACT_NONE,   7'd0,  2'd0},  // right shift down
        {8'd16,  1'b0, ACT_NONE,   7'd0,  2'd0},
        {8'hB6,  1'b1, ACT_NONE,   7'd0,  2'd0},  // right shift up
        {8'd58,  1'b1, ACT_NONE,   7'd0,  2'd0},  // caps on
        {8'd16,  1'b0, ACT_NONE,   7'd0,  2'd0},
        {8'd3,   1'b0, ACT_NONE,   7'd0,  2'd0},  // caps leaves digits alone
        {8'd58,  1'b1, ACT_NONE,   7'd0,  2'd0},  // caps off
        {8'd29,  1'b1, ACT_NONE,   7'd0,  2'd0},  // ctrl down
        {8'd38,  1'b1, ACT_CLEAR,  7'd0,  2'd0},  // ctrl+L
        {8'd46,  1'b1, ACT_HALT,   7'd0,  2'd0},  // ctrl+C
        {8'h9D,  1'b1, ACT_NONE,   7'd0,  2'd0},  // ctrl up
        {8'd59,  1'b1, ACT_NONE,   7'd0,  2'd0},  // F1 without alt
        {8'd56,  1'b1, ACT_NONE,   7'd0,  2'd0},  // alt down
        {8'd61,  1'b1, ACT_SCREEN, 7'd0,  2'd2},  // alt+F3
        {8'hB8,  1'b1, ACT_NONE,   7'd0,  2'd0},  // alt up
        {8'd62,  1'b1, ACT_NONE,   7'd0,  2'd0}   // F4, empty table entry
    };

    // Random codes lean toward key presses and modifier traffic
    function automatic logic [7:0] pick_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            if ($urandom_range(0, 9) == 0)
                return ($urandom_range(0, 1) == 0) ? 8'd74 : 8'd78;
            return 8'($urandom_range(2, 62));
        end else if (sel < 55) begin
            case ($urandom_range(0, 4))
                0: return 8'(KEY_LSHIFT);
                1: return 8'(KEY_RSHIFT);
                2: return 8'(KEY_CTRL);
                3: return 8'(KEY_ALT);
                default: return 8'(KEY_CAPS);
            endcase
        end else if (sel < 70) begin
            case ($urandom_range(0, 3))
                0: return REL_LSHIFT;
                1: return REL_RSHIFT;
                2: return REL_CTRL;
                default: return REL_ALT;
            endcase
        end else if (sel < 80) begin
            case ($urandom_range(0, 4))
                0: return 8'(KEY_L);
                1: return 8'(KEY_C);
                default: return 8'(KEY_F1 + 7'($urandom_range(0, 2)));
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one request and hold it until accepted; valid stays high afterwards
    task automatic put_code(input logic [7:0] code, input logic typed, input t_result typed_res);
        t_result predicted;
        i_valid <= 1'b1;
        i_scan_code <= code;
        do @(posedge i_clk); while (!o_ready);
        predicted = decode_key(code);
        pending_results.push_back(typed ? typed_res : predicted);
        codes_sent++;
    endtask

    // Random sender gap: when allowed, sometimes drops i_valid before the next code
    task automatic sender_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Sender
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < DirectedRows; r++) begin
            put_code(key_rows[r].code, key_rows[r].typed, key_rows[r].res);
            sender_gap(1'b1);
        end
        for (int n = 0; n < RandomCodes; n++) begin
            if (n == DrainPoint) begin
                // hold off until the result side has caught up
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (n == RandomCodes - QuietCodes)
                quiet <= 1'b1;
            put_code(pick_code(), 1'b0, '0);
            sender_gap(n < RandomCodes - QuietCodes);
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // two-stage pipe: keep the clock running to catch any stray result
        repeat (4) @(posedge i_clk);
        $display("Sent %0d scancodes; checked %0d results (%0d characters, %0d control actions)",
                 codes_sent, results_checked, chars_seen, controls_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result action=%0d char=%h screen=%0d",
                             $time, o_action, o_character, o_screen_index);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (o_action == ACT_CHAR)
                        chars_seen++;
                    else if (o_action != ACT_NONE)
                        controls_seen++;
                    if (o_action != want.action) begin
                        $display("%0t: action expected %0d, got %0d",
                                 $time, want.action, o_action);
                        errors++;
                    end
                    if (o_character != want.character) begin
                        $display("%0t: character expected %h, got %h",
                                 $time, want.character, o_character);
                        errors++;
                    end
                    if (o_screen_index != want.screen_index) begin
                        $display("%0t: screen_index expected %0d, got %0d",
                                 $time, want.screen_index, o_screen_index);
                        errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready <= (stall_left == 1);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(1, 4);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end else begin
            i_ready <= 1'b0;
        end
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
